// ===== rtl/hpsb_pkg.sv =====
`default_nettype none
package hpsb_pkg;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int MAP_DEPTH      = 4096;
    localparam int WORD_BITS      = 64;
    localparam int MAP_WORDS      = MAP_DEPTH / WORD_BITS;
    localparam int WORD_AW        = $clog2(MAP_WORDS);
    localparam int POS_W          = $clog2(WORD_BITS);

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 2;
    localparam int RES_W    = 13;
    localparam int OFF_W    = 12;
    localparam int CAP_W    = 12;
    localparam int REC_W    = 13;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIRST  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    localparam logic [REC_W-1:0] REC_RESET = 13'd8;

    typedef logic [WORD_BITS-1:0] t_word;

    // bits below n set, n up to the word width
    function automatic t_word low_mask(input logic [POS_W:0] n);
        t_word m;
        m = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            m[j] = ((POS_W+1)'(j) < n);
        end
        return m;
    endfunction

    // index of the lowest set bit
    function automatic logic [POS_W-1:0] lowest_set(input t_word v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (v[j]) begin
                p = POS_W'(j);
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hpsb_if.sv =====
`default_nettype none
interface hpsb_in_if import hpsb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output op, output slot, input ready);
    modport sink (input valid, input op, input slot, output ready);
endinterface

interface hpsb_out_if import hpsb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RES_W-1:0]    result_slot;
    logic [OFF_W-1:0]    byte_offset;
    logic [CAP_W-1:0]    slot_capacity;

    modport source (output valid, output status, output result_slot, output byte_offset,
                    output slot_capacity, input ready);
    modport sink (input valid, input status, input result_slot, input byte_offset,
                  input slot_capacity, output ready);
endinterface
`default_nettype wire

// ===== rtl/hpsb_ram.sv =====
`default_nettype none
module hpsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/heap_page_slot_bitmap_unit.sv =====
`default_nettype none
// slot bitmap of one page of fixed-size records
// i_in carries words of op and slot; o_out returns one word per item with
// status, result slot, byte offset of the record and the slot capacity
// the record size register is written through i_cfg_wr_en / i_cfg_wr_data
// capacity comes from a restoring divider, one quotient bit a cycle:
//   it runs after reset or a register write,
//   during which i_in.ready stays low
// the bitmap is a 64 x 64-bit ram; one word is examined per cycle
//   first, next and insert: start, then the scan word by word, and for an insert that
//   claims a slot a write; then the multiply for the offset and done
//   delete, get: start, check, a write when a delete frees the slot, multiply, done
//   out-of-range slots, next past the end and unknown ops: multiply and done only
// one item at a time; ready returns once the result sits in the output register
// reset clears the per-row valid bits, so the whole bitmap reads as free at once
// a stalled receiver holds the output register; the next item can be taken
// and worked on, and waits at its end until the output register is free
module heap_page_slot_bitmap_unit import hpsb_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [REC_W-1:0] i_cfg_wr_data,
    hpsb_in_if.sink               i_in,
    hpsb_out_if.source            o_out
);

    localparam int NUM     = PAGE_BYTES * 8;
    localparam int NUM_W   = $clog2(NUM + 1);
    localparam int DCNT_W  = $clog2(NUM_W);
    localparam int DIV_W   = REC_W + 3;
    localparam logic [OFF_W-1:0] PAGE_LO = OFF_W'(PAGE_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_CAP   = 4'd2;
    localparam logic [3:0] S_BASE  = 4'd3;
    localparam logic [3:0] S_START = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_WR    = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]          r_state, n_state;
    logic                r_dirty, n_dirty;
    logic [REC_W-1:0]    r_rec;
    logic [REC_W-1:0]    r_size;
    logic [RES_W-1:0]    r_cap;
    logic [OFF_W-1:0]    r_base;
    logic [DIV_W-1:0]    r_rem;
    logic [NUM_W-1:0]    r_num;
    logic [DCNT_W-1:0]   r_dcnt;
    logic [OP_W-1:0]     r_op;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_from;
    logic [WORD_AW-1:0]  r_word;
    logic [RES_W-1:0]    r_res;
    logic [STATUS_W-1:0] r_status;
    t_word               r_data;
    logic [OFF_W-1:0]    r_prod;
    logic [MAP_WORDS-1:0] r_row_vld;

    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [RES_W-1:0]    r_out_res;
    logic [OFF_W-1:0]    r_out_off;

    // effective record size, clamped to 1..PAGE_BYTES
    logic [REC_W-1:0]    eff_size;
    logic [DIV_W:0]      div_try;
    logic [DIV_W-1:0]    div_den;
    logic                div_ge;
    logic [23:0]         base_prod;

    logic                accept;
    logic [RES_W-1:0]    next_from;
    logic [WORD_AW-1:0]  rd_addr;
    t_word               rd_data;
    t_word               word;
    logic [RES_W-1:0]    rem_bits;
    logic                last_word;
    t_word               mask;
    t_word               cand;
    logic [POS_W-1:0]    hit_pos;
    t_word               bit_sel;
    logic                ram_we;
    t_word               ram_wdata;
    logic                out_free;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;

    assign i_in.ready          = (r_state == S_IDLE) && !r_dirty;
    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out_status;
    assign o_out.result_slot   = r_out_res;
    assign o_out.byte_offset   = r_out_off;
    assign o_out.slot_capacity = r_cap[CAP_W-1:0];

    always_comb begin
        eff_size = (r_rec == '0) ? REC_W'(1) : r_rec;
        if (32'(eff_size) > 32'(PAGE_BYTES)) begin
            eff_size = REC_W'(PAGE_BYTES);
        end
    end

    assign div_den   = {r_size, 3'b001};
    assign div_try   = {r_rem, r_num[NUM_W-1]};
    assign div_ge    = div_try >= {1'b0, div_den};
    assign base_prod = r_size[11:0] * r_cap[11:0];
    assign next_from = RES_W'(i_in.slot) + RES_W'(1);

    // word under examination, free rows read as zero
    assign word      = r_row_vld[r_word] ? rd_data : '0;
    assign rem_bits  = r_cap - RES_W'({r_word, {POS_W{1'b0}}});
    assign last_word = rem_bits <= RES_W'(WORD_BITS);

    always_comb begin
        mask = last_word ? low_mask(rem_bits[POS_W:0]) : '1;
        if (r_word == r_from[SLOT_W-1:POS_W]) begin
            mask = mask & ~low_mask({1'b0, r_from[POS_W-1:0]});
        end
        cand = (r_op == OP_INSERT) ? (~word & mask) : (word & mask);
    end

    assign hit_pos = lowest_set(cand);
    assign bit_sel = t_word'(1) << r_res[POS_W-1:0];

    assign rd_addr   = (r_state == S_SCAN) ? r_word + WORD_AW'(1) : r_word;
    assign ram_we    = (r_state == S_WR);
    assign ram_wdata = (r_op == OP_INSERT) ? (r_data | bit_sel) : (r_data & ~bit_sel);

    hpsb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_res[SLOT_W-1:POS_W]),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_dirty = r_dirty;
        case (r_state)
            S_IDLE: begin
                if (r_dirty) begin
                    n_state = S_DIV;
                    n_dirty = 1'b0;
                end else if (accept) begin
                    case (i_in.op)
                        OP_INSERT, OP_FIRST: n_state = S_START;
                        OP_NEXT: begin
                            n_state = (next_from >= r_cap) ? S_MUL : S_START;
                        end
                        OP_DELETE, OP_GET: begin
                            n_state = (RES_W'(i_in.slot) >= r_cap) ? S_MUL : S_START;
                        end
                        default: n_state = S_MUL;
                    endcase
                end
            end
            S_DIV: begin
                if (r_dcnt == DCNT_W'(NUM_W - 1)) begin
                    n_state = S_CAP;
                end
            end
            S_CAP:   n_state = S_BASE;
            S_BASE:  n_state = S_IDLE;
            S_START: begin
                n_state = (r_op == OP_DELETE || r_op == OP_GET) ? S_CHK : S_SCAN;
            end
            S_SCAN: begin
                if (cand != '0) begin
                    n_state = (r_op == OP_INSERT) ? S_WR : S_MUL;
                end else if (last_word) begin
                    n_state = S_MUL;
                end
            end
            S_CHK: begin
                if (word[r_slot[POS_W-1:0]] && r_op == OP_DELETE) begin
                    n_state = S_WR;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_WR:   n_state = S_MUL;
            S_MUL:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_wr_en) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dirty   <= 1'b1;
            r_rec     <= REC_RESET;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
            if (i_cfg_wr_en) begin
                r_rec <= i_cfg_wr_data;
            end
            if (ram_we) begin
                r_row_vld[r_res[SLOT_W-1:POS_W]] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (r_dirty) begin
                    r_size <= eff_size;
                    r_rem  <= '0;
                    r_num  <= NUM_W'(NUM);
                    r_dcnt <= '0;
                end else if (accept) begin
                    r_op   <= i_in.op;
                    r_slot <= i_in.slot;
                    case (i_in.op)
                        OP_NEXT: begin
                            r_status <= ST_OK;
                            r_res    <= r_cap;
                            r_from   <= next_from[SLOT_W-1:0];
                            r_word   <= next_from[SLOT_W-1:POS_W];
                        end
                        OP_DELETE, OP_GET: begin
                            r_status <= (RES_W'(i_in.slot) >= r_cap) ? ST_RANGE : ST_OK;
                            r_res    <= RES_W'(i_in.slot);
                            r_from   <= '0;
                            r_word   <= i_in.slot[SLOT_W-1:POS_W];
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_res    <= r_cap;
                            r_from   <= '0;
                            r_word   <= '0;
                        end
                    endcase
                end
            end
            S_DIV: begin
                r_rem  <= div_ge ? DIV_W'(div_try - {1'b0, div_den}) : div_try[DIV_W-1:0];
                r_num  <= {r_num[NUM_W-2:0], div_ge};
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            S_CAP: begin
                if (r_num == '0) begin
                    r_cap <= RES_W'(1);
                end else if (32'(r_num) > 32'(MAP_DEPTH)) begin
                    r_cap <= RES_W'(MAP_DEPTH);
                end else begin
                    r_cap <= RES_W'(r_num);
                end
            end
            S_BASE: begin
                // offsets only matter modulo the 12-bit output
                r_base <= PAGE_LO - base_prod[OFF_W-1:0];
            end
            S_SCAN: begin
                if (cand != '0) begin
                    r_res  <= RES_W'({r_word, hit_pos});
                    r_data <= word;
                end else if (last_word) begin
                    r_res <= r_cap;
                    if (r_op == OP_INSERT) begin
                        r_status <= ST_FULL;
                    end
                end else begin
                    r_word <= r_word + WORD_AW'(1);
                end
            end
            S_CHK: begin
                r_data <= word;
                if (!word[r_slot[POS_W-1:0]]) begin
                    r_status <= ST_EMPTY;
                end
            end
            S_MUL: begin
                r_prod <= OFF_W'(r_res[11:0] * r_size[11:0]);
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_res    <= r_res;
                    r_out_off    <= (r_res < r_cap) ? r_base + r_prod : '0;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/hpsb_chk.sv =====
`default_nettype none
module hpsb_chk import hpsb_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] out_status,
    input wire logic [RES_W-1:0]    out_res,
    input wire logic [OFF_W-1:0]    out_off,
    input wire logic [CAP_W-1:0]    out_cap
);

    // a waiting word is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // one item at a time: no word taken in the cycle after one was taken
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // page full reports the capacity as the slot
    a_full_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == ST_FULL |-> out_res[CAP_W-1:0] == out_cap)
        else $error("page full without capacity as slot");

    // a slot out of range has no record
    a_range_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == ST_RANGE |-> out_off == '0)
        else $error("offset given for slot out of range");

endmodule

bind heap_page_slot_bitmap_unit hpsb_chk u_hpsb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_in.valid),
    .in_ready   (i_in.ready),
    .out_valid  (o_out.valid),
    .out_ready  (o_out.ready),
    .out_status (o_out.status),
    .out_res    (o_out.result_slot),
    .out_off    (o_out.byte_offset),
    .out_cap    (o_out.slot_capacity)
);
`default_nettype wire
